// ===== rtl/p2b_pkg.sv =====
// shared types and constants of the pixel to body point transform
// register map codes, reset values and the configuration struct; no dependencies
`default_nettype none

package p2b_pkg;

  // register indexes, one per 8-byte slot of the configuration port
  typedef enum logic [2:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_PRINCIPAL = 3'd2,
    REG_DEPTH     = 3'd3,
    REG_ROT_X     = 3'd4,
    REG_ROT_Y     = 3'd5,
    REG_ROT_Z     = 3'd6,
    REG_OFFSET    = 3'd7
  } reg_idx_t;

  // reset values (identity rotation, no offset)
  localparam logic [15:0] FOCAL_RESET = 16'd16;
  localparam logic [31:0] PRINCIPAL_RESET = 32'd0;
  localparam logic [15:0] DEPTH_RESET = 16'd1000;
  localparam logic [47:0] ROT_X_RESET = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_Y_RESET = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_Z_RESET = 48'h4000_0000_0000;
  localparam logic [47:0] OFFSET_RESET = 48'd0;

  // datapath widths
  localparam int CAM_W  = 33;  // camera frame coordinate, signed
  localparam int PROD_W = 49;  // coefficient times coordinate, signed
  localparam int SUM_W  = 51;  // sum of three products, signed

  // saturation limits
  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // live configuration seen by the datapath
  typedef struct packed {
    logic [15:0]      focal_x;
    logic [15:0]      focal_y;
    logic [15:0]      cx;
    logic [15:0]      cy;
    logic [15:0]      depth;
    logic [2:0][47:0] rot;     // row r: three signed Q2.14 coefficients, column 0 lowest
    logic [47:0]      offset;  // signed mm offsets, x lowest
  } p2b_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/pixel_to_body_point_transform.sv =====
// pixel to body point transform: back-projection at a fixed depth, then rotation and offset
// throughput: one pixel per cycle; the 8-stage radix-16 divider and both multiply stages
// are fully pipelined, and a stall holds each occupied stage while bubbles still close up
// reset: synchronous active-low rst_n empties the pipeline and loads the register defaults
// (focal lengths 16, depth 1000 mm, identity rotation, zero offsets)
// depends on p2b_pkg, p2b_cfg, p2b_proj and p2b_rot
`default_nettype none

module pixel_to_body_point_transform import p2b_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // pixel_u [15:0], pixel_v [31:16]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,   // body_x [31:0], body_y [63:32], body_z [95:64]
  output logic [1:0]       out_tuser,   // zero_focal [0], clipped [1]
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);

  p2b_cfg_t cfg;

  logic                    mid_valid;
  logic                    mid_ready;
  logic signed [CAM_W-1:0] mid_cam_x;
  logic signed [CAM_W-1:0] mid_cam_y;

  logic signed [31:0] body_x;
  logic signed [31:0] body_y;
  logic signed [31:0] body_z;
  logic               zero_focal;
  logic               clipped;

  p2b_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  p2b_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_u      (in_tdata[15:0]),
    .in_v      (in_tdata[31:16]),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_cam_x (mid_cam_x),
    .out_cam_y (mid_cam_y)
  );

  p2b_rot u_rot (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (mid_valid),
    .in_ready       (mid_ready),
    .in_cam_x       (mid_cam_x),
    .in_cam_y       (mid_cam_y),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_x          (body_x),
    .out_y          (body_y),
    .out_z          (body_z),
    .out_zero_focal (zero_focal),
    .out_clipped    (clipped)
  );

  assign out_tdata = {body_z, body_y, body_x};
  assign out_tuser = {clipped, zero_focal};

  // zero focal length gives an all-zero, unclipped result
  a_zero_focal_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && zero_focal |-> (out_tdata == 96'd0) && !clipped)
    else $error("zero focal result not cleared");

  // a clipped result has at least one coordinate at a saturation limit
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && clipped |->
      (body_x == SAT_MAX) || (body_x == SAT_MIN) || (body_y == SAT_MAX) ||
      (body_y == SAT_MIN) || (body_z == SAT_MAX) || (body_z == SAT_MIN))
    else $error("clipped flag without saturated coordinate");

  // an empty output stage lets the whole pipeline move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready && mid_ready)
    else $error("pipeline stalled with empty output");

  // a transfer held in the middle of the pipeline keeps its payload
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mid_valid && !mid_ready |=> mid_valid && $stable(mid_cam_x) && $stable(mid_cam_y))
    else $error("stalled camera point changed");

endmodule

`default_nettype wire

// ===== rtl/p2b_cfg.sv =====
// configuration register file behind an APB-style port
// depends on p2b_pkg for the register map and the configuration struct
`default_nettype none

module p2b_cfg import p2b_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output p2b_cfg_t         cfg
);

  logic [15:0] focal_x_r;
  logic [15:0] focal_y_r;
  logic [31:0] principal_r;
  logic [15:0] depth_r;
  logic [47:0] rot_x_r;
  logic [47:0] rot_y_r;
  logic [47:0] rot_z_r;
  logic [47:0] offset_r;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[5:3]);

  // register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r   <= FOCAL_RESET;
      focal_y_r   <= FOCAL_RESET;
      principal_r <= PRINCIPAL_RESET;
      depth_r     <= DEPTH_RESET;
      rot_x_r     <= ROT_X_RESET;
      rot_y_r     <= ROT_Y_RESET;
      rot_z_r     <= ROT_Z_RESET;
      offset_r    <= OFFSET_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_FOCAL_X:   focal_x_r   <= pwdata[15:0];
        REG_FOCAL_Y:   focal_y_r   <= pwdata[15:0];
        REG_PRINCIPAL: principal_r <= pwdata[31:0];
        REG_DEPTH:     depth_r     <= pwdata[15:0];
        REG_ROT_X:     rot_x_r     <= pwdata[47:0];
        REG_ROT_Y:     rot_y_r     <= pwdata[47:0];
        REG_ROT_Z:     rot_z_r     <= pwdata[47:0];
        REG_OFFSET:    offset_r    <= pwdata[47:0];
      endcase
    end
  end

  // read mux, misaligned addresses read as zero
  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (idx)
        REG_FOCAL_X:   prdata = {48'd0, focal_x_r};
        REG_FOCAL_Y:   prdata = {48'd0, focal_y_r};
        REG_PRINCIPAL: prdata = {32'd0, principal_r};
        REG_DEPTH:     prdata = {48'd0, depth_r};
        REG_ROT_X:     prdata = {16'd0, rot_x_r};
        REG_ROT_Y:     prdata = {16'd0, rot_y_r};
        REG_ROT_Z:     prdata = {16'd0, rot_z_r};
        REG_OFFSET:    prdata = {16'd0, offset_r};
      endcase
    end
  end

  // configuration view for the datapath
  always_comb begin
    cfg.focal_x = focal_x_r;
    cfg.focal_y = focal_y_r;
    cfg.cx      = principal_r[15:0];
    cfg.cy      = principal_r[31:16];
    cfg.depth   = depth_r;
    cfg.rot[0]  = rot_x_r;
    cfg.rot[1]  = rot_y_r;
    cfg.rot[2]  = rot_z_r;
    cfg.offset  = offset_r;
  end

endmodule

`default_nettype wire

// ===== rtl/p2b_proj.sv =====
// back-projection pipeline: centre offset, depth multiply and pipelined divide by focal length
// depends on p2b_pkg for the configuration struct and widths
`default_nettype none

module p2b_proj import p2b_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire p2b_cfg_t           cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_u,
  input  wire logic [15:0]        in_v,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [CAM_W-1:0] out_cam_x,
  output logic signed [CAM_W-1:0] out_cam_y
);

  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = 32 / BITS_PER_STAGE;
  localparam int NS             = 3 + DIV_STAGES + 1;

  // stage valids and per-stage load enables
  logic [NS-1:0] valid_r;
  logic [NS-1:0] valid_in;
  logic [NS:0]   en;

  // lane 0 is x, lane 1 is y
  logic signed [16:0]      diff_r [2];
  logic signed [33:0]      prod_r [2];
  logic        [33:0]      abs_w  [2];
  logic        [15:0]      dvs    [2];
  logic        [15:0]      rem_r  [DIV_STAGES+1][2];
  logic        [31:0]      num_r  [DIV_STAGES+1][2];
  logic                    neg_r  [DIV_STAGES+1][2];
  logic signed [CAM_W-1:0] cam_r  [2];

  // four restoring division steps; quotient bits shift into the low end of num
  function automatic logic [47:0] div_step(input logic [15:0] rem, input logic [31:0] num,
                                           input logic [15:0] d);
    logic [16:0] t;
    logic [16:0] diff;
    logic [15:0] r;
    logic [31:0] n;
    r = rem;
    n = num;
    for (int k = 0; k < BITS_PER_STAGE; k++) begin
      t    = {r, n[31]};
      diff = t - {1'b0, d};
      n    = {n[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r    = diff[15:0];
        n[0] = 1'b1;
      end else begin
        r = t[15:0];
      end
    end
    return {r, n};
  endfunction

  assign dvs[0] = cfg.focal_x;
  assign dvs[1] = cfg.focal_y;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    en[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  assign valid_in  = {valid_r[NS-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = valid_r[NS-1];
  assign out_cam_x = cam_r[0];
  assign out_cam_y = cam_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          valid_r[i] <= valid_in[i];
        end
      end
    end
  end

  // magnitude of the signed numerator
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      abs_w[l] = prod_r[l][33] ? 34'(-prod_r[l]) : 34'(prod_r[l]);
    end
  end

  // offset from centre, times depth
  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff_r[0] <= $signed({1'b0, in_u}) - $signed({1'b0, cfg.cx});
      diff_r[1] <= $signed({1'b0, in_v}) - $signed({1'b0, cfg.cy});
    end
    if (en[1]) begin
      for (int l = 0; l < 2; l++) begin
        prod_r[l] <= diff_r[l] * $signed({1'b0, cfg.depth});
      end
    end
  end

  // numerator magnitude and sign, then divider stages, four quotient bits each
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[0][l] <= '0;
        num_r[0][l] <= abs_w[l][31:0];
        neg_r[0][l] <= prod_r[l][33];
      end
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[3+k]) begin
        for (int l = 0; l < 2; l++) begin
          {rem_r[k+1][l], num_r[k+1][l]} <= div_step(rem_r[k][l], num_r[k][l], dvs[l]);
          neg_r[k+1][l] <= neg_r[k][l];
        end
      end
    end
  end

  // restore the sign, truncated toward zero
  always_ff @(posedge clk) begin
    if (en[3+DIV_STAGES]) begin
      for (int l = 0; l < 2; l++) begin
        cam_r[l] <= neg_r[DIV_STAGES][l] ? -$signed({1'b0, num_r[DIV_STAGES][l]})
                                         :  $signed({1'b0, num_r[DIV_STAGES][l]});
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/p2b_rot.sv =====
// rigid transform pipeline: 3x3 Q2.14 rotation, floor shift, offset and saturation
// depends on p2b_pkg for the configuration struct, widths and limits
`default_nettype none

module p2b_rot import p2b_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire p2b_cfg_t                cfg,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [CAM_W-1:0] in_cam_x,
  input  wire logic signed [CAM_W-1:0] in_cam_y,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [31:0]           out_x,
  output logic signed [31:0]           out_y,
  output logic signed [31:0]           out_z,
  output logic                         out_zero_focal,
  output logic                         out_clipped
);

  localparam int NS = 3;

  logic [NS-1:0] valid_r;
  logic [NS-1:0] valid_in;
  logic [NS:0]   en;

  logic signed [CAM_W-1:0]  cam    [3];
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic signed [SUM_W-1:0]  sum_r  [3];
  logic signed [SUM_W-1:0]  shr_w  [3];
  logic signed [38:0]       tot_w  [3];
  logic signed [31:0]       sat_w  [3];
  logic        [2:0]        clip_w;
  logic                     zero_focal;
  logic signed [31:0]       res_r  [3];
  logic                     zf_r;
  logic                     clip_r;

  assign cam[0] = in_cam_x;
  assign cam[1] = in_cam_y;
  assign cam[2] = $signed({17'd0, cfg.depth});

  // a stage loads when it is empty or its successor loads
  always_comb begin
    en[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  assign valid_in  = {valid_r[NS-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = valid_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          valid_r[i] <= valid_in[i];
        end
      end
    end
  end

  // coefficient products, then row sums
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= $signed(cfg.rot[r][16*c +: 16]) * cam[c];
        end
      end
    end
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= {{2{prod_r[r][0][PROD_W-1]}}, prod_r[r][0]}
                  + {{2{prod_r[r][1][PROD_W-1]}}, prod_r[r][1]}
                  + {{2{prod_r[r][2][PROD_W-1]}}, prod_r[r][2]};
      end
    end
  end

  // floor shift, offset and saturation to 32 bits
  always_comb begin
    zero_focal = (cfg.focal_x == 16'd0) || (cfg.focal_y == 16'd0);
    for (int r = 0; r < 3; r++) begin
      shr_w[r] = sum_r[r] >>> 14;
      tot_w[r] = $signed(shr_w[r][38:0])
               + $signed({{23{cfg.offset[16*r+15]}}, cfg.offset[16*r +: 16]});
      if (tot_w[r] > 39'sd2147483647) begin
        sat_w[r]  = SAT_MAX;
        clip_w[r] = 1'b1;
      end else if (tot_w[r] < -39'sd2147483648) begin
        sat_w[r]  = SAT_MIN;
        clip_w[r] = 1'b1;
      end else begin
        sat_w[r]  = tot_w[r][31:0];
        clip_w[r] = 1'b0;
      end
    end
  end

  // output register, zero focal length forces a zero result
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        res_r[r] <= zero_focal ? 32'sd0 : sat_w[r];
      end
      zf_r   <= zero_focal;
      clip_r <= !zero_focal && (clip_w != 3'b000);
    end
  end

  assign out_x          = res_r[0];
  assign out_y          = res_r[1];
  assign out_z          = res_r[2];
  assign out_zero_focal = zf_r;
  assign out_clipped    = clip_r;

endmodule

`default_nettype wire
